@@ sv/mac_seconds_to_calendar_defines.svh @@
// Assertion macros for the calendar converter checker.
`ifndef MAC_SECONDS_TO_CALENDAR_DEFINES_SVH
`define MAC_SECONDS_TO_CALENDAR_DEFINES_SVH

// Clocked concurrent assertion, disabled while reset is asserted.
`define MSTC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, with a generic message.
`define MSTC_ASSERT_PLAIN(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("calendar converter check failed");

`endif

@@ sv/mstc_pkg.sv @@
// Shared constants, types and tables for the seconds-to-calendar converter.
`timescale 1ns / 1ps

package mstc_pkg;

	// Pipeline depth.
	localparam int NUM_STG = 9;

	typedef struct packed {
		logic [NUM_STG-1:0] en;   // stage may load this cycle
		logic [NUM_STG-1:0] vld;  // stage holds a beat
	} mstc_ctl_t;

	// Calendar constants.
	localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
	localparam int          DAY_SHIFT      = 7;          // 86400 = 675 << 7
	localparam logic [63:0] DAY_ODD        = 64'd675;
	localparam logic [19:0] DAYS_SHIFT     = 20'd695361; // 719468 - 24107
	localparam logic [19:0] ERA5_START     = 20'd730485; // 5 * 146097
	localparam logic [19:0] ERA4_START     = 20'd584388; // 4 * 146097
	localparam logic [17:0] DOE_LAST       = 18'd146096;
	localparam logic [10:0] YEAR_BASE_ERA4 = 11'd1600;
	localparam logic [10:0] YEAR_BASE_ERA5 = 11'd2000;

	// Reciprocal shifts; each multiplier is ceil(2^K / D).
	localparam int K_DAY   = 41;
	localparam int K_HOUR  = 30;
	localparam int K_MIN   = 24;
	localparam int K_1460  = 30;
	localparam int K_36524 = 35;
	localparam int K_365   = 28;
	localparam int K_100   = 17;
	localparam int K_153   = 20;

	localparam logic [63:0] M_DAY_W   = ((64'd1 << K_DAY) + DAY_ODD - 64'd1) / DAY_ODD;
	localparam logic [63:0] M_HOUR_W  = ((64'd1 << K_HOUR) + 64'd3599) / 64'd3600;
	localparam logic [63:0] M_MIN_W   = ((64'd1 << K_MIN) + 64'd59) / 64'd60;
	localparam logic [63:0] M_1460_W  = ((64'd1 << K_1460) + 64'd1459) / 64'd1460;
	localparam logic [63:0] M_36524_W = ((64'd1 << K_36524) + 64'd36523) / 64'd36524;
	localparam logic [63:0] M_365_W   = ((64'd1 << K_365) + 64'd364) / 64'd365;
	localparam logic [63:0] M_100_W   = ((64'd1 << K_100) + 64'd99) / 64'd100;
	localparam logic [63:0] M_153_W   = ((64'd1 << K_153) + 64'd152) / 64'd153;

	localparam logic [31:0] M_DAY   = M_DAY_W[31:0];
	localparam logic [18:0] M_HOUR  = M_HOUR_W[18:0];
	localparam logic [18:0] M_MIN   = M_MIN_W[18:0];
	localparam logic [19:0] M_1460  = M_1460_W[19:0];
	localparam logic [19:0] M_36524 = M_36524_W[19:0];
	localparam logic [19:0] M_365   = M_365_W[19:0];
	localparam logic [10:0] M_100   = M_100_W[10:0];
	localparam logic [12:0] M_153   = M_153_W[12:0];

	// Day-of-year at which each March-based month starts: (153 * mp + 2) / 5.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

@@ sv/mstc_pipe_ctl.sv @@
// Valid tracking and per-stage load enables for the converter pipeline.
`timescale 1ns / 1ps

module mstc_pipe_ctl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_ready,
	output mstc_pkg::mstc_ctl_t ctl
);
	import mstc_pkg::*;

	logic [NUM_STG-1:0] vld_q;
	logic [NUM_STG-1:0] en;

	// A stage loads when empty or when the stage after it moves on.
	always_comb begin
		en[NUM_STG-1] = !vld_q[NUM_STG-1] || out_ready;
		for (int i = NUM_STG - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NUM_STG; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign ctl.en  = en;
	assign ctl.vld = vld_q;

endmodule

@@ sv/mac_seconds_to_calendar.sv @@
// Top level: 32-bit seconds-since-1904 timestamp to calendar date and time of day.
// Usage:
//   Slave channel s_*: one beat per timestamp, s_tdata = seconds since
//   1904-01-01 00:00; zero means no date is set.
//   Master channel m_*: one beat per timestamp, in order. m_tuser is the
//   date-valid flag; when it is low every field in m_tdata is zero.
// An accepted input beat passes through every stage register on its way to m_tvalid.
// Throughput: one beat per cycle while m_tready stays high, through the nine-stage
//   pipeline: day quotient, day count and second of day, era and hour,
//   leap quotients and minute, day-of-era sum, year-of-era, day-of-year,
//   March month, output register.
// Stall: when m_tready is low, the output beat holds; empty stages behind
//   it keep filling, so s_tready drops only once every stage holds a beat.
//   No beat is lost or repeated.
// Reset: arst_n clears all stage valid bits at once; the block accepts a
//   beat as soon as reset is released.
// All divisions are by constants and use reciprocal multiplies, each
//   followed by a register.
`timescale 1ns / 1ps

module mac_seconds_to_calendar (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] mac_seconds
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [10:0] year, [14:11] month, [19:15] day_of_month,
	                               // [24:20] hour, [30:25] minute, [31] zero
	output logic [0:0]  m_tuser    // [0] date_valid
);
	import mstc_pkg::*;

	mstc_ctl_t ctl;

	mstc_pipe_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.out_ready (m_tready),
		.ctl       (ctl)
	);

	assign s_tready = ctl.en[0];

	// ---------------------------------------------------------------
	// Stage 1: hold the timestamp, start the seconds-to-days quotient.
	// 86400 = 675 << 7, so divide the upper 25 bits by 675.
	// ---------------------------------------------------------------
	logic [16:0] tlow_s1;
	logic        nz_s1;
	logic [56:0] pday_s1;

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			tlow_s1 <= s_tdata[16:0];
			nz_s1   <= |s_tdata;
			pday_s1 <= {32'd0, s_tdata[31:DAY_SHIFT]} * {25'd0, M_DAY};
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: day count and second of day.
	// ---------------------------------------------------------------
	logic [15:0] days_c;
	logic [32:0] dsec_c;
	logic [16:0] sod_c;
	logic [15:0] days_s2;
	logic [16:0] sod_s2;
	logic        nz_s2;

	always_comb begin
		days_c = pday_s1[K_DAY+15:K_DAY];
		dsec_c = {17'd0, days_c} * {16'd0, SECS_PER_DAY};
		// sod is below 2^17, so the low bits of the difference suffice
		sod_c  = tlow_s1 - dsec_c[16:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			days_s2 <= days_c;
			sod_s2  <= sod_c;
			nz_s2   <= nz_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: era and day of era; hour and minute of day.
	// The day count only spans eras four and five.
	// ---------------------------------------------------------------
	logic [19:0] z_c;
	logic        era5_c;
	logic [19:0] doe_c;
	logic [35:0] ph_c;
	logic [35:0] pm_c;
	logic [17:0] doe_s3;
	logic        era5_s3;
	logic [4:0]  hour_s3;
	logic [10:0] mod_s3;   // minute of day
	logic        nz_s3;

	always_comb begin
		z_c    = {4'd0, days_s2} + DAYS_SHIFT;
		era5_c = (z_c >= ERA5_START);
		doe_c  = z_c - (era5_c ? ERA5_START : ERA4_START);
		ph_c   = {19'd0, sod_s2} * {17'd0, M_HOUR};
		pm_c   = {19'd0, sod_s2} * {17'd0, M_MIN};
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			doe_s3  <= doe_c[17:0];
			era5_s3 <= era5_c;
			hour_s3 <= ph_c[K_HOUR+4:K_HOUR];
			mod_s3  <= pm_c[K_MIN+10:K_MIN];
			nz_s3   <= nz_s2;
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: leap corrections doe / 1460 and doe / 36524; minute.
	// ---------------------------------------------------------------
	logic [37:0] p1460_c;
	logic [37:0] p36524_c;
	logic [10:0] hmin_c;
	logic [10:0] minute_c;
	logic [17:0] doe_s4;
	logic [6:0]  q1460_s4;
	logic [2:0]  q36524_s4;
	logic        era5_s4;
	logic [4:0]  hour_s4;
	logic [5:0]  minute_s4;
	logic        nz_s4;

	always_comb begin
		p1460_c  = {20'd0, doe_s3} * {18'd0, M_1460};
		p36524_c = {20'd0, doe_s3} * {18'd0, M_36524};
		hmin_c   = {6'd0, hour_s3} * 11'd60;
		minute_c = mod_s3 - hmin_c;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			doe_s4    <= doe_s3;
			q1460_s4  <= p1460_c[K_1460+6:K_1460];
			q36524_s4 <= p36524_c[K_36524+2:K_36524];
			era5_s4   <= era5_s3;
			hour_s4   <= hour_s3;
			minute_s4 <= minute_c[5:0];
			nz_s4     <= nz_s3;
		end
	end

	// ---------------------------------------------------------------
	// Stage 5: corrected day of era, ready for the divide by 365.
	// The last day of an era takes one extra correction.
	// ---------------------------------------------------------------
	logic [17:0] n_c;
	logic [17:0] n_s5;
	logic [17:0] doe_s5;
	logic        era5_s5;
	logic [4:0]  hour_s5;
	logic [5:0]  minute_s5;
	logic        nz_s5;

	always_comb begin
		n_c = doe_s4 - {11'd0, q1460_s4} + {15'd0, q36524_s4}
			- {17'd0, (doe_s4 == DOE_LAST)};
	end

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			n_s5      <= n_c;
			doe_s5    <= doe_s4;
			era5_s5   <= era5_s4;
			hour_s5   <= hour_s4;
			minute_s5 <= minute_s4;
			nz_s5     <= nz_s4;
		end
	end

	// ---------------------------------------------------------------
	// Stage 6: year of era.
	// ---------------------------------------------------------------
	logic [37:0] p365_c;
	logic [8:0]  yoe_s6;
	logic [17:0] doe_s6;
	logic        era5_s6;
	logic [4:0]  hour_s6;
	logic [5:0]  minute_s6;
	logic        nz_s6;

	always_comb begin
		p365_c = {20'd0, n_s5} * {18'd0, M_365};
	end

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			yoe_s6    <= p365_c[K_365+8:K_365];
			doe_s6    <= doe_s5;
			era5_s6   <= era5_s5;
			hour_s6   <= hour_s5;
			minute_s6 <= minute_s5;
			nz_s6     <= nz_s5;
		end
	end

	// ---------------------------------------------------------------
	// Stage 7: day of year (March-based).
	// ---------------------------------------------------------------
	logic [19:0] p100_c;
	logic [1:0]  y100_c;
	logic [17:0] ydays_c;
	logic [17:0] doy_c;
	logic [8:0]  doy_s7;
	logic [8:0]  yoe_s7;
	logic        era5_s7;
	logic [4:0]  hour_s7;
	logic [5:0]  minute_s7;
	logic        nz_s7;

	always_comb begin
		p100_c  = {11'd0, yoe_s6} * {9'd0, M_100};
		y100_c  = p100_c[K_100+1:K_100];
		ydays_c = {9'd0, yoe_s6} * 18'd365;
		doy_c   = doe_s6 - ydays_c - {11'd0, yoe_s6[8:2]} + {16'd0, y100_c};
	end

	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			doy_s7    <= doy_c[8:0];
			yoe_s7    <= yoe_s6;
			era5_s7   <= era5_s6;
			hour_s7   <= hour_s6;
			minute_s7 <= minute_s6;
			nz_s7     <= nz_s6;
		end
	end

	// ---------------------------------------------------------------
	// Stage 8: March-based month index, (5 * doy + 2) / 153.
	// ---------------------------------------------------------------
	logic [10:0] num_c;
	logic [23:0] p153_c;
	logic [3:0]  mp_s8;
	logic [8:0]  doy_s8;
	logic [8:0]  yoe_s8;
	logic        era5_s8;
	logic [4:0]  hour_s8;
	logic [5:0]  minute_s8;
	logic        nz_s8;

	always_comb begin
		num_c  = {2'd0, doy_s7} * 11'd5 + 11'd2;
		p153_c = {13'd0, num_c} * {11'd0, M_153};
	end

	always_ff @(posedge clk) begin
		if (ctl.en[7]) begin
			mp_s8     <= p153_c[K_153+3:K_153];
			doy_s8    <= doy_s7;
			yoe_s8    <= yoe_s7;
			era5_s8   <= era5_s7;
			hour_s8   <= hour_s7;
			minute_s8 <= minute_s7;
			nz_s8     <= nz_s7;
		end
	end

	// ---------------------------------------------------------------
	// Stage 9: output register. January and February belong to the
	// next calendar year. Zero all fields for an unset timestamp.
	// ---------------------------------------------------------------
	logic        jan_feb_c;
	logic [8:0]  day_c;
	logic [3:0]  month_c;
	logic [10:0] year_c;
	logic        valid_s9;
	logic [10:0] year_s9;
	logic [3:0]  month_s9;
	logic [4:0]  day_s9;
	logic [4:0]  hour_s9;
	logic [5:0]  minute_s9;

	always_comb begin
		jan_feb_c = (mp_s8 >= 4'd10);
		day_c     = doy_s8 - month_start(mp_s8) + 9'd1;
		month_c   = jan_feb_c ? (mp_s8 - 4'd9) : (mp_s8 + 4'd3);
		year_c    = (era5_s8 ? YEAR_BASE_ERA5 : YEAR_BASE_ERA4) + {2'd0, yoe_s8}
			+ {10'd0, jan_feb_c};
	end

	always_ff @(posedge clk) begin
		if (ctl.en[8]) begin
			valid_s9  <= nz_s8;
			year_s9   <= nz_s8 ? year_c : '0;
			month_s9  <= nz_s8 ? month_c : '0;
			day_s9    <= nz_s8 ? day_c[4:0] : '0;
			hour_s9   <= nz_s8 ? hour_s8 : '0;
			minute_s9 <= nz_s8 ? minute_s8 : '0;
		end
	end

	assign m_tvalid = ctl.vld[NUM_STG-1];
	assign m_tdata  = {1'b0, minute_s9, hour_s9, day_s9, month_s9, year_s9};
	assign m_tuser  = valid_s9;

endmodule

@@ sv/mstc_checker.sv @@
// Port-level checker for the seconds-to-calendar converter, bound to the top level.
`timescale 1ns / 1ps
`include "mac_seconds_to_calendar_defines.svh"

module mstc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser
);

	logic has_date;
	logic fields_ok;
	logic year_ok;

	assign has_date  = m_tvalid && m_tuser[0];
	assign fields_ok = (m_tdata[14:11] >= 4'd1) && (m_tdata[14:11] <= 4'd12)
		&& (m_tdata[19:15] != 5'd0) && (m_tdata[24:20] < 5'd24)
		&& (m_tdata[30:25] < 6'd60) && !m_tdata[31];
	assign year_ok   = (m_tdata[10:0] >= 11'd1904) && (m_tdata[10:0] <= 11'd2040);

	// Hold the output beat while stalled.
	`MSTC_ASSERT(a_out_hold, clk, arst_n,
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
		"output beat changed while stalled")

	// An unset timestamp gives an all-zero date.
	`MSTC_ASSERT(a_unset_zero, clk, arst_n,
		m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0,
		"unset timestamp produced nonzero fields")

	// Month, hour and minute stay in calendar range, the day is nonzero and bit 31 is zero.
	`MSTC_ASSERT(a_fields_range, clk, arst_n, has_date |-> fields_ok,
		"calendar field out of range")

	// The year stays within what a 32-bit count can reach.
	`MSTC_ASSERT_PLAIN(a_year_range, clk, arst_n, has_date |-> year_ok)

	// With the output stage empty the pipeline can always take a beat.
	`MSTC_ASSERT(a_ready_when_empty, clk, arst_n, !m_tvalid |-> s_tready,
		"input stalled with empty output stage")

endmodule

bind mac_seconds_to_calendar mstc_checker u_mstc_checker (.*);
